@@ rtl/core/drpas_pkg.sv @@
// types and constants for the dns response private address scan block
package drpas_pkg;

   localparam int MAX_BUFFER_BYTES = 1024;
   localparam logic [9:0] MAX_LENGTH_RESET = 10'd512;
   localparam logic [9:0] HEADER_BYTES = 10'd12;

   localparam logic [31:0] TC_A = 32'h0001_0001;
   localparam logic [31:0] TC_AAAA = 32'h001c_0001;
   localparam logic [31:0] TC_CNAME = 32'h0005_0001;

   localparam logic [1:0] VERDICT_QUERY = 2'd0;
   localparam logic [1:0] VERDICT_CLEAN = 2'd1;
   localparam logic [1:0] VERDICT_BLOCK = 2'd2;
   localparam logic [1:0] VERDICT_OVERSIZE = 2'd3;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NAME,
      PH_LABEL,
      PH_PTR2,
      PH_FIXED,
      PH_DATA,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } drpas_req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [9:0] question_end;
      logic [9:0] message_length;
   } drpas_rsp_type;

endpackage

@@ rtl/core/dns_response_private_address_scan.sv @@
// top level: byte-serial dns message parser with private address verdict
// result: the transaction is registered and valid in the cycle after the last byte is accepted
// throughput: one byte per cycle; parser registers update in the accept cycle and the
// verdict sits in a one-entry output register, which stalls the input only while it holds
// a result that the receiver is not taking
// reset (synchronous): clears the parser state and rsp_valid, max_length to 512
module dns_response_private_address_scan
   import drpas_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  drpas_req_type req_payload,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output drpas_rsp_type rsp_payload,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [9:0]    csr_wdata
);

   localparam logic [10:0] BUF_LIMIT = 11'(MAX_BUFFER_BYTES);

   function automatic logic v4_private(input logic [7:0] a, input logic [7:0] b);
      return a == 8'd0 || a == 8'd127 || (a == 8'd169 && b == 8'd254) || a == 8'd10 ||
             (a == 8'd172 && b[7:4] == 4'd1) || (a == 8'd192 && b == 8'd168) ||
             a == 8'd224;
   endfunction

   function automatic logic [4:0] addr_len(input logic [31:0] tc);
      if (tc == TC_A) begin
         return 5'd4;
      end else if (tc == TC_AAAA) begin
         return 5'd16;
      end
      return 5'd0;
   endfunction

   logic [9:0]    max_length_ff, max_length_in;
   logic [9:0]    byte_offset_ff, byte_offset_in;
   phase_type     phase_ff, phase_in;
   logic [15:0]   questions_left_ff, questions_left_in;
   logic [15:0]   answers_left_ff, answers_left_in;
   logic [15:0]   field_acc_ff, field_acc_in;
   logic [31:0]   type_class_ff, type_class_in;
   logic [15:0]   data_left_ff, data_left_in;
   logic [3:0]    addr_flags_ff, addr_flags_in;
   logic [7:0]    prev_byte_ff, prev_byte_in;
   logic          is_response_ff, is_response_in;
   logic          block_ff, block_in;
   logic [9:0]    qend_ff, qend_in;
   logic          too_long_ff, too_long_in;
   logic          rsp_valid_ff, rsp_valid_in;
   drpas_rsp_type rsp_payload_ff, rsp_payload_in;
   logic          rsp_load;
   logic          req_fire;

   logic [7:0]    b;
   logic [9:0]    pos;
   logic [10:0]   n;
   logic [10:0]   limit;
   logic [9:0]    n_sat;
   logic [3:0]    total;
   logic [3:0]    left_sat;
   logic [3:0]    idx;
   logic [15:0]   k;
   logic [4:0]    alen;
   logic [4:0]    alen_end;
   logic [15:0]   diff_end;
   logic          block_end;
   logic [9:0]    qe;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      b     = req_payload.data_byte;
      pos   = byte_offset_ff;
      n     = {1'b0, pos} + 11'd1;
      n_sat = n[10] ? 10'h3ff : n[9:0];
      limit = ({1'b0, max_length_ff} < BUF_LIMIT) ? {1'b0, max_length_ff} : BUF_LIMIT;
      total    = (questions_left_ff != 16'd0) ? 4'd4 : 4'd10;
      left_sat = (data_left_ff > {12'd0, total}) ? total : data_left_ff[3:0];
      idx      = total - left_sat;
      k        = field_acc_ff - data_left_ff;
      alen     = addr_len(type_class_ff);
      alen_end  = 5'd0;
      diff_end  = 16'd0;
      block_end = 1'b0;
      qe        = 10'd0;

      max_length_in     = csr_valid ? csr_wdata : max_length_ff;
      byte_offset_in    = byte_offset_ff;
      phase_in          = phase_ff;
      questions_left_in = questions_left_ff;
      answers_left_in   = answers_left_ff;
      field_acc_in      = field_acc_ff;
      type_class_in     = type_class_ff;
      data_left_in      = data_left_ff;
      addr_flags_in     = addr_flags_ff;
      prev_byte_in      = prev_byte_ff;
      is_response_in    = is_response_ff;
      block_in          = block_ff;
      qend_in           = qend_ff;
      too_long_in       = too_long_ff;
      rsp_load          = 1'b0;
      rsp_payload_in    = rsp_payload_ff;

      if (req_fire) begin
         if (n > limit) begin
            too_long_in = 1'b1;
         end
         byte_offset_in = n_sat;

         case (phase_ff)
            PH_HEADER: begin
               if (pos == 10'd2) is_response_in = b[7];
               if (pos == 10'd4) questions_left_in = {b, 8'd0};
               if (pos == 10'd5) questions_left_in = questions_left_ff | {8'd0, b};
               if (pos == 10'd6) answers_left_in = {b, 8'd0};
               if (pos == 10'd7) answers_left_in = answers_left_ff | {8'd0, b};
               if (pos == 10'd11) begin
                  if (questions_left_ff != 16'd0) begin
                     phase_in = PH_NAME;
                  end else begin
                     qend_in  = HEADER_BYTES;
                     phase_in = (answers_left_ff != 16'd0) ? PH_NAME : PH_DONE;
                  end
               end
            end
            PH_NAME: begin
               if (b[7:6] != 2'd0) begin
                  phase_in = PH_PTR2;
               end else if (b == 8'd0) begin
                  phase_in      = PH_FIXED;
                  data_left_in  = (questions_left_ff != 16'd0) ? 16'd4 : 16'd10;
                  type_class_in = 32'd0;
                  field_acc_in  = 16'd0;
               end else begin
                  data_left_in = {8'd0, b};
                  phase_in     = PH_LABEL;
               end
            end
            PH_LABEL: begin
               if (data_left_ff <= 16'd1) begin
                  data_left_in = 16'd0;
                  phase_in     = PH_NAME;
               end else begin
                  data_left_in = data_left_ff - 16'd1;
               end
            end
            PH_PTR2: begin
               phase_in      = PH_FIXED;
               data_left_in  = (questions_left_ff != 16'd0) ? 16'd4 : 16'd10;
               type_class_in = 32'd0;
               field_acc_in  = 16'd0;
            end
            PH_FIXED: begin
               if (idx < 4'd4) begin
                  type_class_in = {type_class_ff[23:0], b};
               end else if (idx >= 4'd8) begin
                  field_acc_in = {field_acc_ff[7:0], b};
               end
               if (data_left_ff <= 16'd1) begin
                  data_left_in = 16'd0;
                  if (questions_left_ff != 16'd0) begin
                     if (type_class_in == TC_CNAME) block_in = 1'b1;
                     questions_left_in = questions_left_ff - 16'd1;
                     if (questions_left_in == 16'd0) begin
                        qend_in  = n_sat;
                        phase_in = (answers_left_ff != 16'd0) ? PH_NAME : PH_DONE;
                     end else begin
                        phase_in = PH_NAME;
                     end
                  end else begin
                     alen_end = addr_len(type_class_in);
                     if (alen_end != 5'd0 && field_acc_in < {11'd0, alen_end}) begin
                        block_in = 1'b1;
                     end
                     addr_flags_in = 4'b0011;
                     data_left_in  = field_acc_in;
                     if (field_acc_in == 16'd0) begin
                        answers_left_in = answers_left_ff - 16'd1;
                        phase_in = (answers_left_in != 16'd0) ? PH_NAME : PH_DONE;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end else begin
                  data_left_in = data_left_ff - 16'd1;
               end
            end
            PH_DATA: begin
               if (data_left_ff <= field_acc_ff && k < {11'd0, alen}) begin
                  if (type_class_ff == TC_A) begin
                     if (k == 16'd1 && v4_private(prev_byte_ff, b)) block_in = 1'b1;
                  end else begin
                     // ipv6 checks, with ::ffff:a.b.c.d and :: / ::1 tracked in flags
                     if (k < 16'd10 && b != 8'd0) addr_flags_in[0] = 1'b0;
                     if (k >= 16'd10 && k <= 16'd14 && b != 8'd0) addr_flags_in[1] = 1'b0;
                     if (k == 16'd1 && (prev_byte_ff[7:1] == 7'h7e ||
                         (prev_byte_ff == 8'hfe && b[7:6] == 2'd2) ||
                         prev_byte_ff == 8'hff)) begin
                        block_in = 1'b1;
                     end
                     if (k == 16'd10 && b == 8'hff) addr_flags_in[2] = 1'b1;
                     if (k == 16'd11 && addr_flags_in[2] && b == 8'hff) begin
                        addr_flags_in[3] = 1'b1;
                     end
                     if (k == 16'd13 && addr_flags_in[0] && addr_flags_in[3] &&
                         v4_private(prev_byte_ff, b)) begin
                        block_in = 1'b1;
                     end
                     if (k == 16'd15 && addr_flags_in[0] && addr_flags_in[1] &&
                         b <= 8'd1) begin
                        block_in = 1'b1;
                     end
                  end
               end
               prev_byte_in = b;
               if (data_left_ff <= 16'd1) begin
                  data_left_in    = 16'd0;
                  answers_left_in = answers_left_ff - 16'd1;
                  phase_in = (answers_left_in != 16'd0) ? PH_NAME : PH_DONE;
               end else begin
                  data_left_in = data_left_ff - 16'd1;
               end
            end
            default: begin
            end
         endcase

         if (req_payload.last_byte) begin
            // truncated address data blocks
            alen_end  = addr_len(type_class_in);
            diff_end  = field_acc_in - data_left_in;
            block_end = block_in;
            if (questions_left_in == 16'd0 && phase_in == PH_FIXED &&
                data_left_in <= 16'd6 && alen_end != 5'd0) begin
               block_end = 1'b1;
            end
            if (phase_in == PH_DATA && alen_end != 5'd0 && data_left_in <= field_acc_in &&
                diff_end < {11'd0, alen_end}) begin
               block_end = 1'b1;
            end
            if (phase_in != PH_HEADER && questions_left_in == 16'd0) begin
               qe = (qend_in < byte_offset_in) ? qend_in : byte_offset_in;
            end else begin
               qe = byte_offset_in;
            end
            if (too_long_in) begin
               rsp_payload_in.verdict = VERDICT_OVERSIZE;
               qe = 10'd0;
            end else if (!is_response_in) begin
               rsp_payload_in.verdict = VERDICT_QUERY;
            end else begin
               rsp_payload_in.verdict = block_end ? VERDICT_BLOCK : VERDICT_CLEAN;
            end
            rsp_payload_in.question_end   = qe;
            rsp_payload_in.message_length = byte_offset_in;
            rsp_load = 1'b1;

            byte_offset_in    = 10'd0;
            phase_in          = PH_HEADER;
            questions_left_in = 16'd0;
            answers_left_in   = 16'd0;
            field_acc_in      = 16'd0;
            type_class_in     = 32'd0;
            data_left_in      = 16'd0;
            addr_flags_in     = 4'd0;
            prev_byte_in      = 8'd0;
            is_response_in    = 1'b0;
            block_in          = 1'b0;
            qend_in           = 10'd0;
            too_long_in       = 1'b0;
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff     <= MAX_LENGTH_RESET;
         byte_offset_ff    <= 10'd0;
         phase_ff          <= PH_HEADER;
         questions_left_ff <= 16'd0;
         answers_left_ff   <= 16'd0;
         field_acc_ff      <= 16'd0;
         type_class_ff     <= 32'd0;
         data_left_ff      <= 16'd0;
         addr_flags_ff     <= 4'd0;
         prev_byte_ff      <= 8'd0;
         is_response_ff    <= 1'b0;
         block_ff          <= 1'b0;
         qend_ff           <= 10'd0;
         too_long_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         max_length_ff     <= max_length_in;
         byte_offset_ff    <= byte_offset_in;
         phase_ff          <= phase_in;
         questions_left_ff <= questions_left_in;
         answers_left_ff   <= answers_left_in;
         field_acc_ff      <= field_acc_in;
         type_class_ff     <= type_class_in;
         data_left_ff      <= data_left_in;
         addr_flags_ff     <= addr_flags_in;
         prev_byte_ff      <= prev_byte_in;
         is_response_ff    <= is_response_in;
         block_ff          <= block_in;
         qend_ff           <= qend_in;
         too_long_ff       <= too_long_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.last_byte |=> byte_offset_ff == 10'd0 && phase_ff == PH_HEADER)
      else $error("parser state not cleared after last byte");

   a_oversize_qend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.verdict == VERDICT_OVERSIZE |->
      rsp_payload_ff.question_end == 10'd0)
      else $error("oversize verdict with nonzero question end");

   a_qend_in_message: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_payload_ff.question_end <= rsp_payload_ff.message_length &&
      rsp_payload_ff.message_length != 10'd0)
      else $error("question end beyond message length");

endmodule
